[src/msfc_pkg.sv]
package msfc_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned LenWidth   = 16;
   localparam int unsigned IndexWidth = 1;

   localparam logic [WordWidth-1:0] CrcPoly     = 32'hEDB8_8320;
   localparam logic [WordWidth-1:0] AllOnes     = 32'hFFFF_FFFF;
   localparam logic [WordWidth-1:0] MagicReset  = 32'hA55A_5AA5;
   localparam logic [LenWidth-1:0]  PayloadReset = 16'd4096;

   localparam logic [IndexWidth-1:0] RegMagicWord  = 1'b0;
   localparam logic [IndexWidth-1:0] RegPayloadLen = 1'b1;

   typedef struct packed {
      logic [WordWidth-1:0] frame_seq;
      logic                 crc_good;
      logic                 seq_good;
      logic [WordWidth-1:0] good_count;
      logic [WordWidth-1:0] crc_error_count;
      logic [WordWidth-1:0] seq_error_count;
      logic [WordWidth-1:0] frame_count;
   } msfc_result_type;

endpackage

[src/msfc_if.sv]
interface msfc_req_if import msfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface msfc_rsp_if import msfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] frame_seq;
   logic                 crc_good;
   logic                 seq_good;
   logic [WordWidth-1:0] good_count;
   logic [WordWidth-1:0] crc_error_count;
   logic [WordWidth-1:0] seq_error_count;
   logic [WordWidth-1:0] frame_count;

   modport source (
      output valid, output frame_seq, output crc_good, output seq_good,
      output good_count, output crc_error_count, output seq_error_count,
      output frame_count, input ready
   );
   modport sink (
      input valid, input frame_seq, input crc_good, input seq_good,
      input good_count, input crc_error_count, input seq_error_count,
      input frame_count, output ready
   );
endinterface

[src/msfc_out_stage.sv]
module msfc_out_stage import msfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  msfc_result_type result,
   output logic            stalled,
   msfc_rsp_if.source      rsp_chan
);

   logic            valid_ff;
   logic            valid_in;
   msfc_result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign stalled                  = valid_ff && !rsp_chan.ready;
   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.frame_seq       = data_ff.frame_seq;
   assign rsp_chan.crc_good        = data_ff.crc_good;
   assign rsp_chan.seq_good        = data_ff.seq_good;
   assign rsp_chan.good_count      = data_ff.good_count;
   assign rsp_chan.crc_error_count = data_ff.crc_error_count;
   assign rsp_chan.seq_error_count = data_ff.seq_error_count;
   assign rsp_chan.frame_count     = data_ff.frame_count;

endmodule

[src/magic_sync_frame_checker_crc32_core.sv]
// Frame sync / CRC-32 / sequence checker, one received byte per transaction.
// Throughput: one byte per cycle; a byte is held off only when it is the last
// CRC byte of a frame and the previous frame result is still not taken.
// The frame result is registered and appears on rsp in the cycle after its last CRC byte is taken.
// Synchronous active-high reset returns to hunt, clears counters and loads
// the register defaults (magic 0xA55A5AA5, payload length 4096).
module magic_sync_frame_checker_crc32_core import msfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]  csr_wdata,
   msfc_req_if.sink              req_chan,
   msfc_rsp_if.source            rsp_chan
);

   localparam logic [1:0] PhHunt    = 2'd0;
   localparam logic [1:0] PhSeq     = 2'd1;
   localparam logic [1:0] PhPayload = 2'd2;
   localparam logic [1:0] PhCrc     = 2'd3;

   function automatic logic [WordWidth-1:0] crc_byte(
      input logic [WordWidth-1:0] crc,
      input logic [ByteWidth-1:0] data
   );
      logic [WordWidth-1:0] c;
      c = crc;
      for (int i = 0; i < ByteWidth; i++) begin
         c = (c[0] ^ data[i]) ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [WordWidth-1:0] crc_word(input logic [WordWidth-1:0] data);
      logic [WordWidth-1:0] c;
      c = AllOnes;
      for (int i = 0; i < WordWidth; i++) begin
         c = (c[0] ^ data[i]) ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [WordWidth-1:0] shift_in(
      input logic [WordWidth-1:0] word,
      input logic [ByteWidth-1:0] data
   );
      return {data, word[WordWidth-1:ByteWidth]};
   endfunction

   logic [WordWidth-1:0] magic_ff, magic_in;
   logic [LenWidth-1:0]  plen_ff, plen_in;
   logic [1:0]           phase_ff, phase_in;
   logic [WordWidth-1:0] window_ff, window_in;
   logic [2:0]           fill_ff, fill_in;
   logic [LenWidth-1:0]  index_ff, index_in;
   logic [WordWidth-1:0] crc_ff, crc_in;
   logic [WordWidth-1:0] seq_ff, seq_in;
   logic [WordWidth-1:0] field_ff, field_in;
   logic [WordWidth-1:0] expected_ff, expected_in;
   logic [WordWidth-1:0] good_ff, good_in;
   logic [WordWidth-1:0] crc_err_ff, crc_err_in;
   logic [WordWidth-1:0] seq_err_ff, seq_err_in;
   logic [WordWidth-1:0] frames_ff, frames_in;

   logic                 req_fire;
   logic                 last_byte;
   logic                 stalled;
   logic                 load;
   logic [LenWidth-1:0]  index_inc;
   logic                 crc_good;
   logic                 seq_good;
   msfc_result_type      result;

   assign last_byte      = (phase_ff == PhCrc) && (index_ff >= 16'd3);
   assign req_chan.ready = !(last_byte && stalled);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load           = req_fire && last_byte;
   assign index_inc      = index_ff + 16'd1;

   always_comb begin
      magic_in = magic_ff;
      plen_in  = plen_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            RegMagicWord:  magic_in = csr_wdata;
            RegPayloadLen: plen_in  = csr_wdata[LenWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      fill_in     = fill_ff;
      index_in    = index_ff;
      crc_in      = crc_ff;
      seq_in      = seq_ff;
      field_in    = field_ff;
      expected_in = expected_ff;
      good_in     = good_ff;
      crc_err_in  = crc_err_ff;
      seq_err_in  = seq_err_ff;
      frames_in   = frames_ff;
      crc_good    = 1'b0;
      seq_good    = 1'b0;
      if (req_fire) begin
         unique case (phase_ff)
            PhHunt: begin
               window_in = shift_in(window_ff, req_chan.rx_byte);
               fill_in   = (fill_ff < 3'd4) ? fill_ff + 3'd1 : fill_ff;
               if (fill_in == 3'd4 && window_in == magic_ff) begin
                  crc_in   = crc_word(window_in);
                  seq_in   = '0;
                  index_in = '0;
                  phase_in = PhSeq;
               end
            end
            PhSeq: begin
               seq_in   = shift_in(seq_ff, req_chan.rx_byte);
               crc_in   = crc_byte(crc_ff, req_chan.rx_byte);
               index_in = index_inc;
               if (index_inc >= 16'd4) begin
                  index_in = '0;
                  phase_in = (plen_ff == '0) ? PhCrc : PhPayload;
               end
            end
            PhPayload: begin
               crc_in   = crc_byte(crc_ff, req_chan.rx_byte);
               index_in = index_inc;
               if (index_inc >= plen_ff || index_inc == '0) begin
                  index_in = '0;
                  field_in = '0;
                  phase_in = PhCrc;
               end
            end
            PhCrc: begin
               field_in = shift_in(field_ff, req_chan.rx_byte);
               index_in = index_inc;
               if (last_byte) begin
                  crc_good = ((crc_ff ^ AllOnes) == field_in);
                  seq_good = (seq_ff == expected_ff);
                  if (seq_good) begin
                     expected_in = expected_ff + 32'd1;
                  end else begin
                     seq_err_in  = seq_err_ff + 32'd1;
                     expected_in = seq_ff + 32'd1;
                  end
                  if (crc_good) begin
                     good_in = good_ff + 32'd1;
                  end else begin
                     crc_err_in = crc_err_ff + 32'd1;
                  end
                  frames_in = frames_ff + 32'd1;
                  phase_in  = PhHunt;
                  window_in = '0;
                  fill_in   = '0;
                  index_in  = '0;
                  crc_in    = AllOnes;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      result.frame_seq       = seq_ff;
      result.crc_good        = crc_good;
      result.seq_good        = seq_good;
      result.good_count      = good_in;
      result.crc_error_count = crc_err_in;
      result.seq_error_count = seq_err_in;
      result.frame_count     = frames_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff    <= MagicReset;
         plen_ff     <= PayloadReset;
         phase_ff    <= PhHunt;
         window_ff   <= '0;
         fill_ff     <= '0;
         index_ff    <= '0;
         crc_ff      <= AllOnes;
         seq_ff      <= '0;
         field_ff    <= '0;
         expected_ff <= '0;
         good_ff     <= '0;
         crc_err_ff  <= '0;
         seq_err_ff  <= '0;
         frames_ff   <= '0;
      end else begin
         magic_ff    <= magic_in;
         plen_ff     <= plen_in;
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         fill_ff     <= fill_in;
         index_ff    <= index_in;
         crc_ff      <= crc_in;
         seq_ff      <= seq_in;
         field_ff    <= field_in;
         expected_ff <= expected_in;
         good_ff     <= good_in;
         crc_err_ff  <= crc_err_in;
         seq_err_ff  <= seq_err_in;
         frames_ff   <= frames_in;
      end
   end

   msfc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .stalled  (stalled),
      .rsp_chan (rsp_chan)
   );

endmodule

[src/msfc_checker.sv]
module msfc_checker import msfc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WordWidth-1:0] rsp_good_count,
   input logic [WordWidth-1:0] rsp_crc_error_count,
   input logic [WordWidth-1:0] rsp_frame_count
);

   // a pending result stays up until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a pending result holds its good and frame counts until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_good_count, rsp_frame_count}))
      else $error("rsp payload changed while stalled");

   // every frame is either good or a CRC error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> WordWidth'(rsp_good_count + rsp_crc_error_count) == rsp_frame_count)
      else $error("good and crc error counts do not sum to frame count");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind magic_sync_frame_checker_crc32_core msfc_checker u_msfc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_good_count      (rsp_chan.good_count),
   .rsp_crc_error_count (rsp_chan.crc_error_count),
   .rsp_frame_count     (rsp_chan.frame_count)
);

[tb/tb.sv]
module tb;
   import msfc_pkg::*;

   typedef enum logic [1:0] {TokData, TokSeq, TokCrc, TokCsr} stim_kind_type;
   typedef enum logic [1:0] {FrmHunt, FrmSeq, FrmPayload, FrmCrc} frame_phase_type;

   // TokSeq / TokCrc bytes are resolved when driven: lane of the expected
   // sequence or of the running CRC, xor value (zero gives the correct byte).
   typedef struct packed {
      stim_kind_type         kind;
      logic [1:0]            pace;
      logic [1:0]            lane;
      logic [7:0]            value;
      logic [IndexWidth-1:0] csr_index;
      logic [WordWidth-1:0]  csr_data;
      logic [1:0]            typed_id;
   } stim_row_type;

   localparam int unsigned QuietLimit = 1000;
   localparam int unsigned SendGap [3] = '{26, 59, 0};
   localparam int unsigned RecvGap [3] = '{59, 26, 0};

   localparam msfc_result_type TypedResult [1:2] = '{
      '{32'd0, 1'b1, 1'b1, 32'd1, 32'd0, 32'd0, 32'd1},
      '{32'd5, 1'b1, 1'b0, 32'd2, 32'd0, 32'd1, 32'd2}
   };

   // First frame: default magic, one payload byte, sequence 0 as expected.
   // Second frame: zero magic (needs four fresh bytes), no payload, bad sequence.
   localparam stim_row_type DirectedRows [30] = '{
      '{TokCsr,  2'd0, 2'd0, 8'h00, RegPayloadLen, 32'd1, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'hFF, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'hA5, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h5A, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h5A, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'hA5, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h80, RegMagicWord,  32'd0, 2'd0},
      '{TokCrc,  2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokCrc,  2'd0, 2'd1, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokCrc,  2'd0, 2'd2, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokCrc,  2'd0, 2'd3, 8'h00, RegMagicWord,  32'd0, 2'd1},
      '{TokCsr,  2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokCsr,  2'd0, 2'd0, 8'h00, RegPayloadLen, 32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h05, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokData, 2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokCrc,  2'd0, 2'd0, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokCrc,  2'd0, 2'd1, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokCrc,  2'd0, 2'd2, 8'h00, RegMagicWord,  32'd0, 2'd0},
      '{TokCrc,  2'd0, 2'd3, 8'h00, RegMagicWord,  32'd0, 2'd2}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [IndexWidth-1:0] csr_index;
   logic [WordWidth-1:0]  csr_wdata;
   logic                  rsp_ready_q = 1'b0;

   msfc_req_if req_bus ();
   msfc_rsp_if rsp_bus ();

   assign rsp_bus.ready = rsp_ready_q;

   magic_sync_frame_checker_crc32_core dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus)
   );

   always #5 clock = ~clock;

   // frame checker state
   logic [WordWidth-1:0] fc_magic     = MagicReset;
   logic [LenWidth-1:0]  fc_len       = PayloadReset;
   frame_phase_type      fc_phase     = FrmHunt;
   logic [WordWidth-1:0] fc_window    = '0;
   logic [2:0]           fc_fill      = '0;
   logic [LenWidth-1:0]  fc_index     = '0;
   logic [WordWidth-1:0] fc_crc       = AllOnes;
   logic [WordWidth-1:0] fc_seq       = '0;
   logic [WordWidth-1:0] fc_crc_rx    = '0;
   logic [WordWidth-1:0] fc_exp_seq   = '0;
   logic [WordWidth-1:0] fc_good      = '0;
   logic [WordWidth-1:0] fc_crc_err   = '0;
   logic [WordWidth-1:0] fc_seq_err   = '0;
   logic [WordWidth-1:0] fc_frames    = '0;

   msfc_result_type pending_results [$];
   stim_row_type    byte_plan [$];
   int unsigned     fail_count = 0;
   int unsigned     quiet_cycles = 0;
   logic [1:0]      cur_pace = 2'd0;
   int unsigned     send_burst = 0;
   int unsigned     recv_burst = 0;

   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = {24'd0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
      return c ^ (crc >> 8);
   endfunction

   function automatic bit frame_check_step(input logic [7:0] rx, output msfc_result_type res);
      bit done;
      done = 1'b0;
      res = '0;
      case (fc_phase)
         FrmHunt: begin
            fc_window = {rx, fc_window[31:8]};
            if (fc_fill < 3'd4)
               fc_fill = fc_fill + 3'd1;
            if (fc_fill == 3'd4 && fc_window == fc_magic) begin
               fc_crc = AllOnes;
               for (int k = 0; k < 4; k++)
                  fc_crc = crc_update(fc_crc, fc_window[8*k +: 8]);
               fc_seq = '0;
               fc_index = '0;
               fc_phase = FrmSeq;
            end
         end
         FrmSeq: begin
            fc_seq = {rx, fc_seq[31:8]};
            fc_crc = crc_update(fc_crc, rx);
            fc_index = fc_index + 16'd1;
            if (fc_index >= 16'd4) begin
               fc_index = '0;
               fc_phase = (fc_len == '0) ? FrmCrc : FrmPayload;
            end
         end
         FrmPayload: begin
            fc_crc = crc_update(fc_crc, rx);
            fc_index = fc_index + 16'd1;
            if (fc_index >= fc_len || fc_index == '0) begin
               fc_index = '0;
               fc_crc_rx = '0;
               fc_phase = FrmCrc;
            end
         end
         default: begin
            fc_crc_rx = {rx, fc_crc_rx[31:8]};
            fc_index = fc_index + 16'd1;
            if (fc_index >= 16'd4) begin
               res.frame_seq = fc_seq;
               res.crc_good = ((fc_crc ^ AllOnes) == fc_crc_rx);
               res.seq_good = (fc_seq == fc_exp_seq);
               if (res.seq_good) begin
                  fc_exp_seq = fc_exp_seq + 32'd1;
               end else begin
                  fc_seq_err = fc_seq_err + 32'd1;
                  fc_exp_seq = fc_seq + 32'd1;
               end
               if (res.crc_good)
                  fc_good = fc_good + 32'd1;
               else
                  fc_crc_err = fc_crc_err + 32'd1;
               fc_frames = fc_frames + 32'd1;
               res.good_count = fc_good;
               res.crc_error_count = fc_crc_err;
               res.seq_error_count = fc_seq_err;
               res.frame_count = fc_frames;
               fc_phase = FrmHunt;
               fc_window = '0;
               fc_fill = '0;
               fc_index = '0;
               fc_crc = AllOnes;
               done = 1'b1;
            end
         end
      endcase
      return done;
   endfunction

   function automatic bit take_gap(input int unsigned pct, inout int unsigned burst);
      if (burst != 0) begin
         burst--;
         return 1'b0;
      end
      if ($urandom_range(0, 99) < 3) begin
         burst = $urandom_range(16, 64);
         return 1'b0;
      end
      return $urandom_range(0, 99) < pct;
   endfunction

   task automatic push_row(input stim_kind_type kind, input logic [1:0] lane,
                           input logic [7:0] value, input logic [1:0] pace);
      byte_plan.push_back(stim_row_type'{kind, pace, lane, value, RegMagicWord, 32'd0, 2'd0});
   endtask

   task automatic add_frame(input logic [31:0] magic, input logic [15:0] len,
                            input logic [1:0] pace, input bit clean);
      int unsigned noise, mode, pos, sel, drop_at;
      logic [7:0]  flip, pick;
      logic [31:0] word;
      noise = clean ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                                       : $urandom_range(0, 3));
      for (int unsigned k = 0; k < noise; k++) begin
         sel = $urandom_range(0, 3);
         pick = $urandom_range(0, 1) ? magic[8*sel +: 8] : 8'($urandom);
         push_row(TokData, 2'd0, pick, pace);
      end
      pos = $urandom_range(0, 3);
      flip = (!clean && $urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      for (int k = 0; k < 4; k++)
         push_row(TokData, 2'd0, magic[8*k +: 8] ^ ((k == pos) ? flip : 8'h00), pace);
      mode = clean ? 0 : $urandom_range(0, 9);
      word = (mode == 8) ? 32'hFFFF_FFFF : $urandom;
      pos = $urandom_range(0, 3);
      flip = 8'($urandom_range(1, 255));
      for (int k = 0; k < 4; k++) begin
         if (mode == 7 || mode == 8)
            push_row(TokData, 2'd0, word[8*k +: 8], pace);
         else if (mode == 9)
            push_row(TokSeq, 2'(k), (k == pos) ? flip : 8'h00, pace);
         else
            push_row(TokSeq, 2'(k), 8'h00, pace);
      end
      drop_at = (!clean && len != 0 && $urandom_range(0, 19) == 0)
                ? $urandom_range(0, len - 1) : len;
      for (int unsigned k = 0; k < len; k++) begin
         pick = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                            : 8'($urandom);
         if (k != drop_at)
            push_row(TokData, 2'd0, pick, pace);
      end
      mode = clean ? 0 : $urandom_range(0, 19);
      word = $urandom;
      pos = $urandom_range(0, 3);
      flip = 8'($urandom_range(1, 255));
      for (int k = 0; k < 4; k++) begin
         if (mode == 19)
            push_row(TokData, 2'd0, word[8*k +: 8], pace);
         else if (mode >= 17)
            push_row(TokCrc, 2'(k), (k == pos) ? flip : 8'h00, pace);
         else
            push_row(TokCrc, 2'(k), 8'h00, pace);
      end
   endtask

   task automatic add_phase(input logic [31:0] magic, input logic [15:0] len,
                            input logic [1:0] pace, input int unsigned budget, input bit clean);
      int unsigned start;
      byte_plan.push_back(stim_row_type'{TokCsr, pace, 2'd0, 8'h00, RegMagicWord, magic, 2'd0});
      byte_plan.push_back(stim_row_type'{TokCsr, pace, 2'd0, 8'h00, RegPayloadLen,
                                         {16'd0, len}, 2'd0});
      start = byte_plan.size();
      while (byte_plan.size() - start < budget)
         add_frame(magic, len, pace, clean);
   endtask

   initial begin
      stim_row_type    row;
      msfc_result_type res;
      logic [7:0]      b;
      logic [31:0]     crc_now;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= RegMagicWord;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= '0;

      // directed table first, then random settings
      foreach (DirectedRows[i])
         byte_plan.push_back(DirectedRows[i]);
      add_phase($urandom, 16'd1, 2'd0, 200, 1'b0);
      add_phase(32'hFFFF_FFFF, 16'd2, 2'd0, 200, 1'b0);
      add_phase(32'h0000_0000, 16'd3, 2'd1, 200, 1'b0);
      add_phase($urandom, 16'($urandom_range(4, 40)), 2'd1, 200, 1'b0);
      add_phase($urandom, 16'd0, 2'd2, 200, 1'b0);
      add_phase({4{8'($urandom)}}, 16'($urandom_range(1, 8)), 2'd2, 200, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (byte_plan.size() != 0) begin
         row = byte_plan.pop_front();
         cur_pace = row.pace;
         if (row.kind == TokCsr) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0)
               @(posedge clock);
            repeat (4) @(posedge clock);
            csr_write_en <= 1'b1;
            csr_index <= row.csr_index;
            csr_wdata <= row.csr_data;
            @(posedge clock);
            csr_write_en <= 1'b0;
            if (row.csr_index == RegMagicWord)
               fc_magic = row.csr_data;
            else
               fc_len = row.csr_data[LenWidth-1:0];
         end else begin
            while (take_gap(SendGap[row.pace], send_burst)) begin
               req_bus.valid <= 1'b0;
               @(posedge clock);
            end
            crc_now = fc_crc ^ AllOnes;
            case (row.kind)
               TokSeq:  b = fc_exp_seq[8*row.lane +: 8] ^ row.value;
               TokCrc:  b = crc_now[8*row.lane +: 8] ^ row.value;
               default: b = row.value;
            endcase
            req_bus.valid <= 1'b1;
            req_bus.rx_byte <= b;
            do @(posedge clock); while (!req_bus.ready);
            if (frame_check_step(b, res))
               pending_results.push_back((row.typed_id != 0) ? TypedResult[row.typed_id] : res);
         end
      end
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("magic_sync_frame_checker_crc32_core test passed");
      else
         $display("magic_sync_frame_checker_crc32_core test failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready_q <= !take_gap(RecvGap[cur_pace], recv_burst);
   end

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      msfc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction: expected none actual frame_seq %0h",
                     $time, rsp_bus.frame_seq);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.frame_seq !== want.frame_seq)
               report_field("frame_seq", want.frame_seq, rsp_bus.frame_seq);
            if (rsp_bus.crc_good !== want.crc_good)
               report_field("crc_good", want.crc_good, rsp_bus.crc_good);
            if (rsp_bus.seq_good !== want.seq_good)
               report_field("seq_good", want.seq_good, rsp_bus.seq_good);
            if (rsp_bus.good_count !== want.good_count)
               report_field("good_count", want.good_count, rsp_bus.good_count);
            if (rsp_bus.crc_error_count !== want.crc_error_count)
               report_field("crc_error_count", want.crc_error_count, rsp_bus.crc_error_count);
            if (rsp_bus.seq_error_count !== want.seq_error_count)
               report_field("seq_error_count", want.seq_error_count, rsp_bus.seq_error_count);
            if (rsp_bus.frame_count !== want.frame_count)
               report_field("frame_count", want.frame_count, rsp_bus.frame_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("magic_sync_frame_checker_crc32_core test failed");
         $finish;
      end
   end

endmodule
